/* rtl/rsc_pkg.sv */
// Shared constants, types and helpers for the rotate/scale source coordinate generator.
package rsc_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS     = 16;
    localparam int ACC_BITS      = 48;
    localparam int CFG_SIZE_BITS = 13;
    localparam int STEP_BITS     = 32;
    localparam int SIZE_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS     = STEP_BITS + COORD_BITS + 1;
    localparam int RND_BITS      = ACC_BITS + 1 - FRAC_BITS;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    // Cycles for the frame start point to settle after a register write
    localparam int SETTLE_CYCLES = 2;
    localparam int SETTLE_BITS   = 2;

    // Edge band around the source image
    localparam int BAND_LOW  = -2;
    localparam int BAND_HIGH = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_STEP_COS   = 3'd4,
        REG_STEP_SIN   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                  in_band;
        logic [COORD_BITS-1:0] coord;
    } axis_t;

    // Saturate a size register to 1 .. 2^COORD_BITS
    function automatic logic [SIZE_BITS-1:0] sat_size(input logic [CFG_SIZE_BITS-1:0] r);
        logic [31:0] rw;
        logic [31:0] lim;
        rw  = 32'(r);
        lim = 32'(1) << COORD_BITS;
        if (rw == 32'd0)
            return SIZE_BITS'(1);
        else if (rw > lim)
            return SIZE_BITS'(lim);
        else
            return SIZE_BITS'(rw);
    endfunction

    // Last index of a saturated size
    function automatic logic [COORD_BITS-1:0] last_idx(input logic [CFG_SIZE_BITS-1:0] r);
        logic [SIZE_BITS-1:0] s;
        s = sat_size(r) - SIZE_BITS'(1);
        return s[COORD_BITS-1:0];
    endfunction

    // Integer half of a saturated size
    function automatic logic [COORD_BITS-1:0] half_size(input logic [CFG_SIZE_BITS-1:0] r);
        logic [SIZE_BITS-1:0] s;
        s = sat_size(r) >> 1;
        return s[COORD_BITS-1:0];
    endfunction

endpackage

/* rtl/rotate_scale_source_coordinate_gen.sv */
// Rotate/scale inverse mapping: destination raster walk and rounded source coordinates.
// Pipeline: an accepted item is written to the stage register and then to the result
// register, where it is offered; result back-pressure can hold it in the stage register.
// Throughput: one item per cycle; outside the settle window below, ready is held off by
// result back-pressure only.
// After reset and after every register write the frame start point is recomputed
// by a two-stage multiply/add, and items are not taken until the settle counter is zero.
// Reset: registers return to 64x64 / unit step, accumulators and row/column counters to zero.
module rotate_scale_source_coordinate_gen (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rsc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [rsc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [rsc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              restart,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [rsc_pkg::COORD_BITS-1:0]    dst_x,
    output logic [rsc_pkg::COORD_BITS-1:0]    dst_y,
    output logic [rsc_pkg::COORD_BITS-1:0]    src_x,
    output logic [rsc_pkg::COORD_BITS-1:0]    src_y,
    output logic                              inside_res,
    output logic                              last_in_row,
    output logic                              last_in_frame
);
    import rsc_pkg::*;

    localparam logic [ACC_BITS:0] HALF = (ACC_BITS+1)'(1) << (FRAC_BITS - 1);

    // Configuration registers
    logic [CFG_SIZE_BITS-1:0]   src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic signed [STEP_BITS-1:0] step_cos_reg, step_sin_reg;
    logic [SETTLE_BITS-1:0]     settle_cnt_reg;
    logic                       cfg_wr;
    reg_idx_t                   reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[REG_IDX_BITS+1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= CFG_SIZE_BITS'(64);
            src_height_reg <= CFG_SIZE_BITS'(64);
            dst_width_reg  <= CFG_SIZE_BITS'(64);
            dst_height_reg <= CFG_SIZE_BITS'(64);
            step_cos_reg   <= STEP_BITS'(65536);
            step_sin_reg   <= '0;
            settle_cnt_reg <= SETTLE_BITS'(SETTLE_CYCLES);
        end
        else
        begin
            if (cfg_wr)
            begin
                settle_cnt_reg <= SETTLE_BITS'(SETTLE_CYCLES);
                case (reg_idx)
                    REG_SRC_WIDTH:  src_width_reg  <= pwdata[CFG_SIZE_BITS-1:0];
                    REG_SRC_HEIGHT: src_height_reg <= pwdata[CFG_SIZE_BITS-1:0];
                    REG_DST_WIDTH:  dst_width_reg  <= pwdata[CFG_SIZE_BITS-1:0];
                    REG_DST_HEIGHT: dst_height_reg <= pwdata[CFG_SIZE_BITS-1:0];
                    REG_STEP_COS:   step_cos_reg   <= pwdata[STEP_BITS-1:0];
                    REG_STEP_SIN:   step_sin_reg   <= pwdata[STEP_BITS-1:0];
                    default: ;
                endcase
            end
            else if (settle_cnt_reg != '0)
            begin
                settle_cnt_reg <= settle_cnt_reg - SETTLE_BITS'(1);
            end
        end
    end

    // Register read-back
    always_comb
    begin
        case (reg_idx)
            REG_SRC_WIDTH:  prdata = APB_DATA_BITS'(src_width_reg);
            REG_SRC_HEIGHT: prdata = APB_DATA_BITS'(src_height_reg);
            REG_DST_WIDTH:  prdata = APB_DATA_BITS'(dst_width_reg);
            REG_DST_HEIGHT: prdata = APB_DATA_BITS'(dst_height_reg);
            REG_STEP_COS:   prdata = APB_DATA_BITS'(unsigned'(step_cos_reg));
            REG_STEP_SIN:   prdata = APB_DATA_BITS'(unsigned'(step_sin_reg));
            default:        prdata = '0;
        endcase
    end

    // Frame start point: products registered, then summed
    logic [COORD_BITS-1:0]       cxd, cyd;
    logic signed [PROD_BITS-1:0] prod_xc_reg, prod_ys_reg, prod_xs_reg, prod_yc_reg;
    logic [ACC_BITS-1:0]         base_u_reg, base_v_reg;
    logic [ACC_BITS-1:0]         start_u_reg, start_v_reg;
    logic signed [STEP_BITS-1:0] sc, su;

    assign cxd = half_size(dst_width_reg);
    assign cyd = half_size(dst_height_reg);
    assign sc  = step_cos_reg;
    assign su  = step_sin_reg;

    always_ff @(posedge clk)
    begin
        prod_xc_reg <= $signed({1'b0, cxd}) * sc;
        prod_ys_reg <= $signed({1'b0, cyd}) * su;
        prod_xs_reg <= $signed({1'b0, cxd}) * su;
        prod_yc_reg <= $signed({1'b0, cyd}) * sc;
        base_u_reg  <= ACC_BITS'(half_size(src_width_reg)) << FRAC_BITS;
        base_v_reg  <= ACC_BITS'(half_size(src_height_reg)) << FRAC_BITS;
        start_u_reg <= base_u_reg - ACC_BITS'(prod_xc_reg) - ACC_BITS'(prod_ys_reg);
        start_v_reg <= base_v_reg + ACC_BITS'(prod_xs_reg) - ACC_BITS'(prod_yc_reg);
    end

    // Handshake and pipeline control
    logic s1_valid_reg, res_valid_reg;
    logic s1_load, out_load;

    assign out_load   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign item_ready = (settle_cnt_reg == '0) && (!s1_valid_reg || out_load);
    assign s1_load    = item_valid && item_ready;
    assign res_valid  = res_valid_reg;

    // Raster walk state
    logic [ACC_BITS-1:0]   row_u_reg, row_v_reg, pix_u_reg, pix_v_reg;
    logic [ACC_BITS-1:0]   row_u_next, row_v_next, pix_u_next, pix_v_next;
    logic [COORD_BITS-1:0] col_cnt_reg, row_cnt_reg, col_cnt_next, row_cnt_next;
    logic [ACC_BITS-1:0]   cur_row_u, cur_row_v, cur_pix_u, cur_pix_v, row_u_step, row_v_step;
    logic [COORD_BITS-1:0] cur_col, cur_row, last_col, last_row;
    logic                  end_row, end_frame;

    assign last_col = last_idx(dst_width_reg);
    assign last_row = last_idx(dst_height_reg);

    always_comb
    begin
        // restart reloads the start point for this very item
        cur_row_u  = restart ? start_u_reg : row_u_reg;
        cur_row_v  = restart ? start_v_reg : row_v_reg;
        cur_pix_u  = restart ? start_u_reg : pix_u_reg;
        cur_pix_v  = restart ? start_v_reg : pix_v_reg;
        cur_col    = restart ? '0 : col_cnt_reg;
        cur_row    = restart ? '0 : row_cnt_reg;
        end_row    = cur_col >= last_col;
        end_frame  = end_row && (cur_row >= last_row);
        row_u_step = cur_row_u + ACC_BITS'(su);
        row_v_step = cur_row_v + ACC_BITS'(sc);

        if (end_frame)
        begin
            row_u_next   = start_u_reg;
            row_v_next   = start_v_reg;
            pix_u_next   = start_u_reg;
            pix_v_next   = start_v_reg;
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (end_row)
        begin
            row_u_next   = row_u_step;
            row_v_next   = row_v_step;
            pix_u_next   = row_u_step;
            pix_v_next   = row_v_step;
            col_cnt_next = '0;
            row_cnt_next = cur_row + COORD_BITS'(1);
        end
        else
        begin
            row_u_next   = cur_row_u;
            row_v_next   = cur_row_v;
            pix_u_next   = cur_pix_u + ACC_BITS'(sc);
            pix_v_next   = cur_pix_v - ACC_BITS'(su);
            col_cnt_next = cur_col + COORD_BITS'(1);
            row_cnt_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_u_reg    <= '0;
            row_v_reg    <= '0;
            pix_u_reg    <= '0;
            pix_v_reg    <= '0;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                row_u_reg   <= row_u_next;
                row_v_reg   <= row_v_next;
                pix_u_reg   <= pix_u_next;
                pix_v_reg   <= pix_v_next;
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (out_load)
                s1_valid_reg <= 1'b0;
        end
    end

    // Stage register: this pixel's accumulator values and position
    logic [ACC_BITS-1:0]   s1_u_reg, s1_v_reg;
    logic [COORD_BITS-1:0] s1_x_reg, s1_y_reg;
    logic                  s1_end_row_reg, s1_end_frame_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_u_reg         <= cur_pix_u;
            s1_v_reg         <= cur_pix_v;
            s1_x_reg         <= cur_col;
            s1_y_reg         <= cur_row;
            s1_end_row_reg   <= end_row;
            s1_end_frame_reg <= end_frame;
        end
    end

    // Round half away from zero: (a + half - sign) >>> FRAC_BITS
    function automatic logic signed [RND_BITS-1:0] acc_round(input logic [ACC_BITS-1:0] a);
        logic signed [ACC_BITS:0] sum;
        sum = $signed({a[ACC_BITS-1], a}) + $signed(HALF)
            - $signed((ACC_BITS+1)'(a[ACC_BITS-1]));
        return $signed(sum[ACC_BITS:FRAC_BITS]);
    endfunction

    // Edge band test and clamp for one axis
    function automatic axis_t map_axis(input logic signed [RND_BITS-1:0] s,
                                       input logic [COORD_BITS-1:0] last);
        axis_t                      r;
        logic signed [RND_BITS-1:0] last_s;
        last_s    = $signed(RND_BITS'(last));
        r.in_band = (s >= RND_BITS'(BAND_LOW)) && (s <= last_s + RND_BITS'(BAND_HIGH));
        if (s < $signed(RND_BITS'(0)))
            r.coord = '0;
        else if (s > last_s)
            r.coord = last;
        else
            r.coord = s[COORD_BITS-1:0];
        return r;
    endfunction

    axis_t ax_u, ax_v;
    logic  pix_inside;

    assign ax_u       = map_axis(acc_round(s1_u_reg), last_idx(src_width_reg));
    assign ax_v       = map_axis(acc_round(s1_v_reg), last_idx(src_height_reg));
    assign pix_inside = ax_u.in_band && ax_v.in_band;

    // Result register
    logic [COORD_BITS-1:0] dst_x_reg, dst_y_reg, src_x_reg, src_y_reg;
    logic                  inside_reg, last_row_flag_reg, last_frame_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (out_load)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dst_x_reg           <= s1_x_reg;
            dst_y_reg           <= s1_y_reg;
            src_x_reg           <= pix_inside ? ax_u.coord : '0;
            src_y_reg           <= pix_inside ? ax_v.coord : '0;
            inside_reg          <= pix_inside;
            last_row_flag_reg   <= s1_end_row_reg;
            last_frame_flag_reg <= s1_end_frame_reg;
        end
    end

    assign dst_x         = dst_x_reg;
    assign dst_y         = dst_y_reg;
    assign src_x         = src_x_reg;
    assign src_y         = src_y_reg;
    assign inside_res    = inside_reg;
    assign last_in_row   = last_row_flag_reg;
    assign last_in_frame = last_frame_flag_reg;

    // Checks
    a_no_take_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !item_ready)
        else $error("item taken while start point settles");

    a_frame_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last_in_frame |-> last_in_row)
        else $error("frame end without row end");

    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !inside_res |-> (src_x == '0) && (src_y == '0))
        else $error("fill pixel carries a source coordinate");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        s1_load && end_frame |=> (col_cnt_reg == '0) && (row_cnt_reg == '0))
        else $error("counters not cleared at frame end");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_load |=> s1_valid_reg && $stable(s1_u_reg))
        else $error("stage item lost under back-pressure");

endmodule
